>>> rtl/binary_trie_max_xor_top_macros.svh
// Assertion macros used by the trie block's top-level RTL file.
`ifndef BINARY_TRIE_MAX_XOR_TOP_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BMX_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trie block check failed (same cycle)");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define BMX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trie block check failed (next cycle)");

`endif

>>> rtl/bmx_pkg.sv
// Package with the operation codes, sequencer states and link store controls.
`timescale 1ns / 1ps

package bmx_pkg;

	// Operation codes carried in the func field of an input beat.
	typedef enum logic [1:0] {
		FN_CLEAR        = 2'd0,
		FN_INSERT       = 2'd1,
		FN_QUERY        = 2'd2,
		FN_QUERY_INSERT = 2'd3
	} func_t;

	// Sequencer states: one trie level is walked per cycle in the walk states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUERY,
		ST_COUNT,
		ST_ALLOC,
		ST_LEAF,
		ST_DONE
	} state_t;

	// Control group from the sequencer to the link store.
	typedef struct packed {
		logic wr;        // write one node entry
		logic clr;       // empty the trie (root links to null)
		logic use_root;  // current node is the root
		logic use_fresh; // current node was just allocated, links are null
	} lnk_ctl_t;

endpackage

>>> rtl/bmx_link_store.sv
// Child link store: root links in flip-flops, all other nodes in a RAM.
`timescale 1ns / 1ps

module bmx_link_store #(
	parameter int NODE_COUNT = 8192
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bmx_pkg::lnk_ctl_t                ctl,
	input  logic [$clog2(NODE_COUNT)-1:0]    wr_addr,
	input  logic [2*$clog2(NODE_COUNT)-1:0]  wr_data,
	input  logic [$clog2(NODE_COUNT)-1:0]    rd_addr,
	output logic [2*$clog2(NODE_COUNT)-1:0]  pair
);

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int PAIR_W = 2 * NODE_W;

	logic [PAIR_W-1:0] root_q;
	logic [PAIR_W-1:0] mem [NODE_COUNT];
	logic [PAIR_W-1:0] rd_q;

	// The root entry is the only one with a defined reset, so it lives in flops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (ctl.clr) begin
			root_q <= '0;
		end else if (ctl.wr && wr_addr == '0) begin
			root_q <= wr_data;
		end
	end

	// Node RAM: one write port, one read port with registered read data.
	always_ff @(posedge clk) begin
		if (ctl.wr && wr_addr != '0) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Links of the current node: root flops, known-null fresh node, or RAM data.
	always_comb begin
		if (ctl.use_root) begin
			pair = root_q;
		end else if (ctl.use_fresh) begin
			pair = '0;
		end else begin
			pair = rd_q;
		end
	end

endmodule

>>> rtl/binary_trie_max_xor_top.sv
// Binary trie maximum-XOR block: sequencer, walk datapath and result register.
// One trie level is walked per cycle, set by the single node RAM read port.
// Throughput: one item at a time; the next beat is taken once the result is queued.
// Reset empties the trie (root links null, next free node 1); other RAM entries are
// written as nodes are allocated, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "binary_trie_max_xor_top_macros.svh"

module binary_trie_max_xor_top #(
	parameter int KEY_BITS   = 31,
	parameter int NODE_COUNT = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [KEY_BITS-1:0] key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KEY_BITS-1:0] max_xor,
	output logic                pool_full
);

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int PAIR_W = 2 * NODE_W;
	localparam int CNT_W  = $clog2(NODE_COUNT + 1);
	localparam int LVL_W  = $clog2(KEY_BITS + 1);
	localparam int CMP_W  = (CNT_W > LVL_W) ? CNT_W : LVL_W;

	bmx_pkg::state_t    state_q, state_d;
	bmx_pkg::func_t     func_q;
	bmx_pkg::lnk_ctl_t  ctl;

	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] mask_q;
	logic [KEY_BITS-1:0] best_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [NODE_W-1:0]   node_q;
	logic                cur_root_q;
	logic                fresh_q;
	logic [CNT_W-1:0]    next_free_q;
	logic                full_q;
	logic                out_valid_q;
	logic [KEY_BITS-1:0] max_xor_q;
	logic                pool_full_q;

	logic                in_fire;
	logic                out_free;
	logic [PAIR_W-1:0]   pair;
	logic                key_bit;
	logic [NODE_W-1:0]   link0, link1, link_d, link_o;
	logic                last_lvl;
	logic                alloc_now;
	logic                no_room;
	logic [NODE_W-1:0]   new_node;
	logic [CNT_W-1:0]    free_cnt;
	logic [NODE_W-1:0]   nxt_node;
	logic                nxt_fresh;
	logic                walk_init;
	logic                walk_state;
	logic [NODE_W-1:0]   wr_addr;
	logic [PAIR_W-1:0]   wr_data;

	assign in_fire  = in_valid && !in_stall;
	assign in_stall = (state_q != bmx_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign max_xor   = max_xor_q;
	assign pool_full = pool_full_q;

	// Decode the current node's links against the key bit at this level.
	always_comb begin
		link0     = pair[NODE_W-1:0];
		link1     = pair[PAIR_W-1:NODE_W];
		key_bit   = |(key_q & mask_q);
		link_d    = key_bit ? link1 : link0;
		link_o    = key_bit ? link0 : link1;
		last_lvl  = (lvl_q == LVL_W'(1));
		alloc_now = fresh_q || (link_d == '0);
		new_node  = next_free_q[NODE_W-1:0];
		free_cnt  = CNT_W'(NODE_COUNT) - next_free_q;
		no_room   = CMP_W'(lvl_q) > CMP_W'(free_cnt);
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmx_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (bmx_pkg::func_t'(func))
						bmx_pkg::FN_CLEAR:  state_d = bmx_pkg::ST_DONE;
						bmx_pkg::FN_INSERT: state_d = bmx_pkg::ST_COUNT;
						default:            state_d = bmx_pkg::ST_QUERY;
					endcase
				end
			end
			bmx_pkg::ST_QUERY: begin
				if (last_lvl || (link_o == '0 && link_d == '0)) begin
					state_d = (func_q == bmx_pkg::FN_QUERY_INSERT) ?
						bmx_pkg::ST_COUNT : bmx_pkg::ST_DONE;
				end
			end
			bmx_pkg::ST_COUNT: begin
				if (link_d == '0) begin
					state_d = no_room ? bmx_pkg::ST_DONE : bmx_pkg::ST_ALLOC;
				end else if (last_lvl) begin
					state_d = bmx_pkg::ST_DONE;
				end
			end
			bmx_pkg::ST_ALLOC: begin
				if (last_lvl) begin
					state_d = alloc_now ? bmx_pkg::ST_LEAF : bmx_pkg::ST_DONE;
				end
			end
			bmx_pkg::ST_LEAF: begin
				state_d = bmx_pkg::ST_DONE;
			end
			bmx_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = bmx_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bmx_pkg::ST_IDLE;
			end
		endcase
	end

	// Output logic: store controls, link writes and the next node of the walk.
	always_comb begin
		ctl.wr        = 1'b0;
		ctl.clr       = 1'b0;
		ctl.use_root  = cur_root_q;
		ctl.use_fresh = fresh_q;
		wr_addr       = node_q;
		wr_data       = pair;
		nxt_node      = link_d;
		nxt_fresh     = 1'b0;
		case (state_q)
			bmx_pkg::ST_IDLE: begin
				ctl.clr = in_fire && (bmx_pkg::func_t'(func) == bmx_pkg::FN_CLEAR);
			end
			bmx_pkg::ST_QUERY: begin
				nxt_node = (link_o != '0) ? link_o : link_d;
			end
			bmx_pkg::ST_ALLOC: begin
				if (alloc_now) begin
					ctl.wr    = 1'b1;
					wr_data   = key_bit ? {new_node, link0} : {link1, new_node};
					nxt_node  = new_node;
					nxt_fresh = 1'b1;
				end
			end
			bmx_pkg::ST_LEAF: begin
				ctl.wr  = 1'b1;
				wr_data = '0;
			end
			default: begin
				ctl.wr = 1'b0;
			end
		endcase
	end

	assign walk_state = (state_q == bmx_pkg::ST_QUERY) || (state_q == bmx_pkg::ST_COUNT) ||
		(state_q == bmx_pkg::ST_ALLOC);
	assign walk_init  = (state_d != state_q) &&
		(state_d inside {bmx_pkg::ST_QUERY, bmx_pkg::ST_COUNT, bmx_pkg::ST_ALLOC});

	bmx_link_store #(
		.NODE_COUNT (NODE_COUNT)
	) u_links (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (nxt_node),
		.pair    (pair)
	);

	// Sequencer state, pool counter and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmx_pkg::ST_IDLE;
			next_free_q <= CNT_W'(1);
			out_valid_q <= 1'b0;
			cur_root_q  <= 1'b1;
			fresh_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.clr) begin
				next_free_q <= CNT_W'(1);
			end else if (state_q == bmx_pkg::ST_ALLOC && alloc_now) begin
				next_free_q <= next_free_q + CNT_W'(1);
			end
			if (state_q == bmx_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (walk_init) begin
				cur_root_q <= 1'b1;
				fresh_q    <= 1'b0;
			end else if (walk_state) begin
				cur_root_q <= 1'b0;
				fresh_q    <= nxt_fresh;
			end
		end
	end

	// Walk datapath: current node, level, key mask and best XOR so far.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q  <= key;
			func_q <= bmx_pkg::func_t'(func);
			best_q <= '0;
			full_q <= 1'b0;
		end
		if (walk_init) begin
			node_q <= '0;
			lvl_q  <= LVL_W'(KEY_BITS);
			mask_q <= KEY_BITS'(1) << (KEY_BITS - 1);
		end else if (walk_state) begin
			node_q <= nxt_node;
			lvl_q  <= lvl_q - LVL_W'(1);
			mask_q <= mask_q >> 1;
		end
		if (state_q == bmx_pkg::ST_QUERY && link_o != '0) begin
			best_q <= best_q | mask_q;
		end
		if (state_q == bmx_pkg::ST_COUNT && link_d == '0 && no_room) begin
			full_q <= 1'b1;
		end
		if (state_q == bmx_pkg::ST_DONE && out_free) begin
			max_xor_q   <= best_q;
			pool_full_q <= full_q;
		end
	end

	// The pool counter never leaves its range.
	`BMX_ASSERT_IMPL(a_free_range, 1'b1, next_free_q >= CNT_W'(1) && next_free_q <= CNT_W'(NODE_COUNT))
	// An allocation only happens when a free node is left.
	`BMX_ASSERT_IMPL(a_alloc_room, state_q == bmx_pkg::ST_ALLOC && alloc_now, next_free_q < CNT_W'(NODE_COUNT))
	// An accepted beat always makes the sequencer busy in the next cycle.
	`BMX_ASSERT_NEXT(a_accept_busy, in_fire, state_q != bmx_pkg::ST_IDLE)
	// The leaf write always targets a node that was just allocated.
	`BMX_ASSERT_IMPL(a_leaf_fresh, state_q == bmx_pkg::ST_LEAF, fresh_q && !cur_root_q)

endmodule

>>> sim/trie_result_checker.sv
// Result checker for the trie block: predicts every result beat and compares it.
`timescale 1ns / 1ps

module trie_result_checker #(
	parameter int KEY_BITS   = 31,
	parameter int NODE_COUNT = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          func,
	input  logic [KEY_BITS-1:0] key,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [KEY_BITS-1:0] max_xor,
	input  logic                pool_full,
	output int                  errors,
	output int                  pending,
	output int                  results_checked,
	output int                  inserts_dropped
);

	typedef struct packed {
		logic [KEY_BITS-1:0] xor_val;
		logic                full;
	} trie_result_t;

	// Shadow trie: two child links per node, zero meaning no child.
	int unsigned child_of [NODE_COUNT][2];
	int unsigned free_node;

	// Result beats still owed by the block, oldest first.
	trie_result_t owed_results [$];

	// Empty the shadow trie; nodes get their links zeroed when allocated.
	function automatic void empty_trie();
		child_of[0][0] = 0;
		child_of[0][1] = 0;
		free_node = 1;
	endfunction

	// Walk toward the opposite bit at each level wherever that child exists.
	function automatic logic [KEY_BITS-1:0] best_xor(input logic [KEY_BITS-1:0] k);
		int unsigned node;
		logic [KEY_BITS-1:0] best;
		bit walking;
		int lv;
		node = 0;
		best = '0;
		walking = 1'b1;
		for (lv = KEY_BITS - 1; lv >= 0; lv--) begin
			if (walking) begin
				if (child_of[node][!k[lv]] != 0) begin
					best[lv] = 1'b1;
					node = child_of[node][!k[lv]];
				end else if (child_of[node][k[lv]] != 0) begin
					node = child_of[node][k[lv]];
				end else begin
					walking = 1'b0;
				end
			end
		end
		return best;
	endfunction

	// Add the key path; returns 1 when the missing nodes do not all fit.
	function automatic bit add_key(input logic [KEY_BITS-1:0] k);
		int unsigned node;
		int unsigned nxt;
		int unsigned needed;
		bit gap_found;
		int lv;
		node = 0;
		needed = 0;
		gap_found = 1'b0;
		for (lv = KEY_BITS - 1; lv >= 0; lv--) begin
			if (!gap_found) begin
				nxt = child_of[node][k[lv]];
				if (nxt == 0) begin
					needed = lv + 1;
					gap_found = 1'b1;
				end else begin
					node = nxt;
				end
			end
		end
		if (needed > NODE_COUNT - free_node)
			return 1'b1;
		node = 0;
		for (lv = KEY_BITS - 1; lv >= 0; lv--) begin
			nxt = child_of[node][k[lv]];
			if (nxt == 0) begin
				nxt = free_node;
				free_node++;
				child_of[nxt][0] = 0;
				child_of[nxt][1] = 0;
				child_of[node][k[lv]] = nxt;
			end
			node = nxt;
		end
		return 1'b0;
	endfunction

	// Predict on every input beat, compare on every output beat.
	always @(posedge clk or negedge arst_n) begin
		trie_result_t predicted;
		trie_result_t oldest;
		int miss;
		int drop;
		int done;
		if (!arst_n) begin
			empty_trie();
			owed_results.delete();
			errors <= 0;
			pending <= 0;
			results_checked <= 0;
			inserts_dropped <= 0;
		end else begin
			miss = 0;
			drop = 0;
			done = 0;
			if (in_valid && !in_stall) begin
				predicted = '0;
				case (func)
					bmx_pkg::FN_CLEAR: begin
						empty_trie();
					end
					bmx_pkg::FN_INSERT: begin
						predicted.full = add_key(key);
					end
					bmx_pkg::FN_QUERY: begin
						predicted.xor_val = best_xor(key);
					end
					default: begin
						predicted.xor_val = best_xor(key);
						predicted.full = add_key(key);
					end
				endcase
				if (predicted.full)
					drop = 1;
				owed_results.push_back(predicted);
			end
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result beat with nothing owed, max_xor %h pool_full %b",
						$time, max_xor, pool_full);
					miss++;
				end else begin
					oldest = owed_results.pop_front();
					done = 1;
					if (max_xor !== oldest.xor_val) begin
						$display("%0t: max_xor mismatch, expected %h, actual %h",
							$time, oldest.xor_val, max_xor);
						miss++;
					end
					if (pool_full !== oldest.full) begin
						$display("%0t: pool_full mismatch, expected %b, actual %b",
							$time, oldest.full, pool_full);
						miss++;
					end
				end
			end
			errors <= errors + miss;
			pending <= owed_results.size();
			results_checked <= results_checked + done;
			inserts_dropped <= inserts_dropped + drop;
		end
	end

endmodule

>>> sim/tb_top.sv
// Testbench top for the trie block: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 120;
	localparam int PHASE_BEATS    = 667;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [30:0] key;
	logic        out_valid;
	logic        out_stall;
	logic [30:0] max_xor;
	logic        pool_full;

	int errors;
	int pending;
	int results_checked;
	int inserts_dropped;

	int send_idle_pct;
	int recv_idle_pct;
	int beats_sent;
	int quiet_cycles;
	int hold_left;
	logic hold_ticket;
	logic hold_seen;
	logic [30:0] inserted_keys [$];

	binary_trie_max_xor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.key       (key),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.max_xor   (max_xor),
		.pool_full (pool_full)
	);

	trie_result_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.key             (key),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.max_xor         (max_xor),
		.pool_full       (pool_full),
		.errors          (errors),
		.pending         (pending),
		.results_checked (results_checked),
		.inserts_dropped (inserts_dropped)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver: random stalls, plus one long hold-off whenever the ticket flips.
	always @(posedge clk) begin
		if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: too long without a beat on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offer one beat after a random gap and hold it until the block takes it.
	task automatic send_beat(input bmx_pkg::func_t f, input logic [30:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		key <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		if (f == bmx_pkg::FN_INSERT || f == bmx_pkg::FN_QUERY_INSERT) begin
			inserted_keys.push_back(k);
			if (inserted_keys.size() > 1024)
				void'(inserted_keys.pop_front());
		end
	endtask

	// One trie lifetime: a clear, then random operations. A pool-filling
	// episode uses mostly fresh random keys so the node pool runs out.
	task automatic run_episode(input int beats, input bit fill_pool);
		int n;
		int pick;
		bmx_pkg::func_t f;
		logic [30:0] k;
		logic [30:0] stored;
		logic [31:0] r;
		logic [31:0] mask;
		r = $urandom;
		send_beat(bmx_pkg::FN_CLEAR, r[30:0]);
		for (n = 0; n < beats; n++) begin
			pick = $urandom_range(99);
			if (fill_pool)
				f = (pick < 45) ? bmx_pkg::FN_INSERT :
					(pick < 90) ? bmx_pkg::FN_QUERY_INSERT : bmx_pkg::FN_QUERY;
			else
				f = (pick < 3) ? bmx_pkg::FN_CLEAR : (pick < 33) ? bmx_pkg::FN_INSERT :
					(pick < 58) ? bmx_pkg::FN_QUERY : bmx_pkg::FN_QUERY_INSERT;
			if (inserted_keys.size() > 0)
				stored = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
			else
				stored = '0;
			pick = $urandom_range(99);
			r = $urandom;
			if (pick < (fill_pool ? 85 : 30)) begin
				k = r[30:0];
			end else if (pick < (fill_pool ? 93 : 60)) begin
				k = stored;
			end else if (pick < (fill_pool ? 100 : 85)) begin
				// Share a prefix with a stored key: only the low bits under a random mask differ.
				mask = (32'd1 << $urandom_range(30)) - 32'd1;
				r = {1'b0, stored} ^ (r & mask);
				k = r[30:0];
			end else begin
				case ($urandom_range(3))
					0: k = '0;
					1: k = '1;
					2: begin
						r = 32'd1 << $urandom_range(30);
						k = r[30:0];
					end
					default: k = ~stored;
				endcase
			end
			send_beat(f, k);
		end
	endtask

	initial begin
		int phase;
		int quota;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = bmx_pkg::FN_CLEAR;
		key = '0;
		out_stall = 1'b0;
		hold_ticket = 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		beats_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct <= 47;
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct <= 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
					// Long output hold-off while the sender keeps offering.
					hold_ticket <= ~hold_ticket;
				end
			endcase

			if (phase == 0) begin
				// Directed: empty trie, key extremes, duplicates and every operation.
				send_beat(bmx_pkg::FN_CLEAR, 31'h0);
				send_beat(bmx_pkg::FN_QUERY, 31'h0);
				send_beat(bmx_pkg::FN_QUERY, 31'h7fff_ffff);
				send_beat(bmx_pkg::FN_QUERY_INSERT, 31'h0000_1234);
				send_beat(bmx_pkg::FN_INSERT, 31'h0);
				send_beat(bmx_pkg::FN_INSERT, 31'h7fff_ffff);
				send_beat(bmx_pkg::FN_QUERY, 31'h0);
				send_beat(bmx_pkg::FN_QUERY, 31'h7fff_ffff);
				send_beat(bmx_pkg::FN_INSERT, 31'h0);
				send_beat(bmx_pkg::FN_QUERY_INSERT, 31'h5555_5555);
				send_beat(bmx_pkg::FN_QUERY, 31'h2aaa_aaaa);
				send_beat(bmx_pkg::FN_INSERT, 31'h4000_0000);
				send_beat(bmx_pkg::FN_QUERY, 31'h3fff_ffff);
				send_beat(bmx_pkg::FN_QUERY_INSERT, 31'h0000_0001);
				send_beat(bmx_pkg::FN_QUERY_INSERT, 31'h0000_0001);
				send_beat(bmx_pkg::FN_CLEAR, 31'h7fff_ffff);
				send_beat(bmx_pkg::FN_QUERY, 31'h7fff_ffff);
				send_beat(bmx_pkg::FN_INSERT, 31'h0000_0001);
				send_beat(bmx_pkg::FN_QUERY, 31'h0);
				send_beat(bmx_pkg::FN_QUERY_INSERT, 31'h7fff_fffe);
			end

			quota = beats_sent + PHASE_BEATS;
			run_episode(500, 1'b1);
			while (beats_sent < quota)
				run_episode($urandom_range(5, 60), 1'b0);
		end
		in_valid <= 1'b0;

		// Drain: everything owed must arrive, then allow the block to settle.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d input beats of all four operations over three idling phases,",
			beats_sent);
		$display("checked %0d result beats; %0d inserts were dropped on a full node pool.",
			results_checked, inserts_dropped);
		if (pending != 0)
			$display("%0t: %0d result beats never arrived", $time, pending);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/bmx_pkg.sv
rtl/bmx_link_store.sv
rtl/binary_trie_max_xor_top.sv
sim/trie_result_checker.sv
sim/tb_top.sv
